// File: sv/urs_pkg.sv
`default_nettype none
package urs_pkg;

	localparam int ECHO_COUNT_BITS_DEF = 16;
	localparam int PERIOD_BITS_DEF     = 24;

	localparam int ESCAPE_BITS = 16;
	localparam int DIST_BITS   = 11;
	localparam int PERIOD_REG_BITS  = 24;
	localparam int TIMEOUT_REG_BITS = 16;
	localparam int TIMER_BITS  = 3;
	localparam int REM_BITS    = 6;

	localparam int TICKS_PER_CM = 29;
	localparam int ROUND_TRIP   = 2;
	// floor(floor(t/29)/2) == floor(t/58)
	localparam int TICKS_PER_STEP = TICKS_PER_CM * ROUND_TRIP;

	localparam logic [TIMER_BITS-1:0] LOW_TICKS  = TIMER_BITS'(2);
	localparam logic [TIMER_BITS-1:0] HIGH_TICKS = TIMER_BITS'(5);
	localparam logic [REM_BITS-1:0]   REM_LAST   = REM_BITS'(TICKS_PER_STEP - 1);
	localparam logic [DIST_BITS-1:0]  DIST_MAX   = '1;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AUTO_MODE      = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_PERIOD  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ECHO_TIMEOUT   = 2'd2;

	localparam logic                        AUTO_MODE_RST = 1'b1;
	localparam logic [PERIOD_REG_BITS-1:0]  SAMPLE_PERIOD_RST = 24'd50000;
	localparam logic [TIMEOUT_REG_BITS-1:0] ECHO_TIMEOUT_RST  = 16'd2000;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TRIG_LOW  = 3'd1,
		PH_TRIG_HIGH = 3'd2,
		PH_WAIT_RISE = 3'd3,
		PH_MEASURE   = 3'd4,
		PH_DONE      = 3'd5
	} phase_t;

	typedef struct packed {
		logic                        auto_mode;
		logic [PERIOD_REG_BITS-1:0]  sample_period_ticks;
		logic [TIMEOUT_REG_BITS-1:0] echo_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic                 trigger_level;
		logic [DIST_BITS-1:0] range_cm;
		logic                 distance_valid;
		logic                 timed_out;
		logic                 busy_res;
	} result_t;

endpackage
`default_nettype wire

// File: sv/urs_ifs.sv
`default_nettype none
interface urs_in_if;
	logic valid;
	logic ready;
	logic echo_level;
	logic start_request;
	modport source (output valid, output echo_level, output start_request, input ready);
	modport sink (input valid, input echo_level, input start_request, output ready);
endinterface

interface urs_out_if;
	import urs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 trigger_level;
	logic [DIST_BITS-1:0] range_cm;
	logic                 distance_valid;
	logic                 timed_out;
	logic                 busy_res;
	modport source (output valid, output trigger_level, output range_cm,
		output distance_valid, output timed_out, output busy_res, input ready);
	modport sink (input valid, input trigger_level, input range_cm,
		input distance_valid, input timed_out, input busy_res, output ready);
endinterface

interface urs_cfg_if;
	import urs_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/urs_cfg.sv
`default_nettype none
module urs_cfg (
	input  wire logic      clk,
	input  wire logic      arst_n,
	urs_cfg_if.sink        cfg,
	output urs_pkg::cfg_t  regs
);
	import urs_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.auto_mode           <= AUTO_MODE_RST;
			regs_q.sample_period_ticks <= SAMPLE_PERIOD_RST;
			regs_q.echo_timeout_ticks  <= ECHO_TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_AUTO_MODE: regs_q.auto_mode <= cfg.data[0];
				CFG_SAMPLE_PERIOD: regs_q.sample_period_ticks <= cfg.data[PERIOD_REG_BITS-1:0];
				CFG_ECHO_TIMEOUT: regs_q.echo_timeout_ticks <= cfg.data[TIMEOUT_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/urs_seq.sv
`default_nettype none
module urs_seq #(
	parameter int ECHO_COUNT_BITS = urs_pkg::ECHO_COUNT_BITS_DEF,
	parameter int PERIOD_BITS     = urs_pkg::PERIOD_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic          echo_level,
	input  wire logic          start_request,
	input  wire urs_pkg::cfg_t cfg,
	output urs_pkg::result_t   res
);
	import urs_pkg::*;

	// echo time kept as quotient/remainder by 58 alongside the raw count
	localparam int QW  = ECHO_COUNT_BITS - 5;
	localparam int QXW = (QW > DIST_BITS) ? QW : DIST_BITS;
	localparam int CW  = (PERIOD_BITS > PERIOD_REG_BITS) ? PERIOD_BITS : PERIOD_REG_BITS;

	phase_t                     phase_q, phase_d, ph;
	logic [TIMER_BITS-1:0]      timer_q, timer_d;
	logic [ESCAPE_BITS-1:0]     esc_q, esc_d, esc_inc;
	logic [ECHO_COUNT_BITS-1:0] echo_q, echo_d;
	logic [REM_BITS-1:0]        rem_q, rem_d;
	logic [QW-1:0]              quot_q, quot_d;
	logic [PERIOD_BITS-1:0]     period_q, period_d;
	logic [DIST_BITS-1:0]       dist_q, dist_d;
	logic                       auto_go, esc_hit;

	always_comb begin
		esc_inc = (esc_q != '1) ? esc_q + 1'b1 : esc_q;
		esc_hit = {1'b0, esc_inc} >= {1'b0, cfg.echo_timeout_ticks};
	end

	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_q;
		esc_d    = esc_q;
		echo_d   = echo_q;
		rem_d    = rem_q;
		quot_d   = quot_q;
		period_d = period_q;
		dist_d   = dist_q;
		res      = '0;
		auto_go  = 1'b0;

		unique case (phase_q)
			PH_TRIG_LOW, PH_TRIG_HIGH, PH_WAIT_RISE, PH_MEASURE, PH_DONE: ph = phase_q;
			default: ph = PH_IDLE;
		endcase

		if (cfg.auto_mode) begin
			if (period_q != '1)
				period_d = period_q + 1'b1;
		end else begin
			period_d = '0;
		end

		if (cfg.auto_mode && ph == PH_IDLE &&
				CW'(period_d) >= CW'(cfg.sample_period_ticks))
			auto_go = 1'b1;
		if ((ph == PH_IDLE || ph == PH_DONE) && (start_request || auto_go)) begin
			ph      = PH_TRIG_LOW;
			timer_d = '0;
		end
		if (auto_go)
			period_d = '0;

		phase_d = ph;
		unique case (ph)
			PH_TRIG_LOW: begin
				res.busy_res = 1'b1;
				timer_d = timer_d + 1'b1;
				if (timer_d >= LOW_TICKS) begin
					phase_d = PH_TRIG_HIGH;
					timer_d = '0;
				end
			end
			PH_TRIG_HIGH: begin
				res.busy_res = 1'b1;
				res.trigger_level = 1'b1;
				timer_d = timer_d + 1'b1;
				if (timer_d >= HIGH_TICKS) begin
					phase_d = PH_WAIT_RISE;
					timer_d = '0;
					esc_d   = '0;
				end
			end
			PH_WAIT_RISE: begin
				res.busy_res = 1'b1;
				if (echo_level) begin
					phase_d = PH_MEASURE;
					echo_d  = '0;
					rem_d   = '0;
					quot_d  = '0;
					esc_d   = '0;
				end else if (esc_hit) begin
					esc_d   = '0;
					phase_d = PH_IDLE;
					res.timed_out = 1'b1;
				end else begin
					esc_d = esc_inc;
				end
			end
			PH_MEASURE: begin
				res.busy_res = 1'b1;
				if (echo_q != '1) begin
					echo_d = echo_q + 1'b1;
					if (rem_q == REM_LAST) begin
						rem_d  = '0;
						quot_d = quot_q + 1'b1;
					end else begin
						rem_d = rem_q + 1'b1;
					end
				end
				if (!echo_level) begin
					if (QXW'(quot_d) > QXW'(DIST_MAX))
						dist_d = DIST_MAX;
					else
						dist_d = DIST_BITS'(quot_d);
					res.distance_valid = 1'b1;
					esc_d   = '0;
					phase_d = cfg.auto_mode ? PH_IDLE : PH_DONE;
				end else if (esc_hit) begin
					esc_d   = '0;
					phase_d = PH_IDLE;
					res.timed_out = 1'b1;
				end else begin
					esc_d = esc_inc;
				end
			end
			default: ;
		endcase

		res.range_cm = dist_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			timer_q  <= '0;
			esc_q    <= '0;
			echo_q   <= '0;
			rem_q    <= '0;
			quot_q   <= '0;
			period_q <= '0;
			dist_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			esc_q    <= esc_d;
			echo_q   <= echo_d;
			rem_q    <= rem_d;
			quot_q   <= quot_d;
			period_q <= period_d;
			dist_q   <= dist_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/ultrasonic_range_sequencer_core.sv
// A tick word accepted into the input register (v_s1) steps the sequencer into the result
// register (res_q), from which it is presented as a result word.
// Throughput: one tick word per cycle unless a result waits; one sequencer step per word.
// The input register lets a new word in while the previous result waits, if it is empty.
// Reset (arst_n low, asynchronous): idle phase, all counters and distance cleared,
// auto mode on, sample period 50000, echo timeout 2000.
`default_nettype none
module ultrasonic_range_sequencer_core #(
	parameter int ECHO_COUNT_BITS = urs_pkg::ECHO_COUNT_BITS_DEF,
	parameter int PERIOD_BITS     = urs_pkg::PERIOD_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	urs_in_if.sink    tick,
	urs_out_if.source result,
	urs_cfg_if.sink   cfg
);
	import urs_pkg::*;

	cfg_t    regs;
	result_t res, res_q;
	logic    v_s1, echo_s1, start_s1, out_v_q;
	logic    adv, step;

	assign adv  = !out_v_q || result.ready;
	assign step = v_s1 && adv;
	assign tick.ready = !v_s1 || adv;

	urs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	urs_seq #(
		.ECHO_COUNT_BITS (ECHO_COUNT_BITS),
		.PERIOD_BITS     (PERIOD_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.echo_level    (echo_s1),
		.start_request (start_s1),
		.cfg           (regs),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (tick.ready)
				v_s1 <= tick.valid;
			if (adv)
				out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			echo_s1  <= tick.echo_level;
			start_s1 <= tick.start_request;
		end
		if (step)
			res_q <= res;
	end

	assign result.valid          = out_v_q;
	assign result.trigger_level  = res_q.trigger_level;
	assign result.range_cm       = res_q.range_cm;
	assign result.distance_valid = res_q.distance_valid;
	assign result.timed_out      = res_q.timed_out;
	assign result.busy_res       = res_q.busy_res;

endmodule
`default_nettype wire

// File: tb/sv/range_sequencer_checker.sv
module range_sequencer_checker (
	input  logic clk,
	input  logic arst_n,
	urs_in_if    tick,
	urs_out_if   result,
	urs_cfg_if   cfg,
	output int   mismatches,
	output int   pending,
	output int   distances_seen,
	output int   timeouts_seen
);
	import urs_pkg::*;

	cfg_t                           regs;
	phase_t                         ph;
	logic [TIMER_BITS-1:0]          ph_timer;
	logic [ESCAPE_BITS-1:0]         escape_cnt;
	logic [ECHO_COUNT_BITS_DEF-1:0] pulse_ticks;
	logic [PERIOD_BITS_DEF-1:0]     period_cnt;
	logic [DIST_BITS-1:0]           last_cm;
	result_t                        expected_q[$];

	// one waiting tick; true once the echo timeout is reached
	function automatic bit escape_expired();
		if (escape_cnt != '1)
			escape_cnt++;
		return escape_cnt >= regs.echo_timeout_ticks;
	endfunction

	function automatic result_t advance(input logic echo, input logic start);
		result_t                        r;
		logic                           go;
		logic [ECHO_COUNT_BITS_DEF-1:0] cm;
		r = '0;
		if (ph > PH_DONE)
			ph = PH_IDLE;
		if (regs.auto_mode) begin
			if (period_cnt != '1)
				period_cnt++;
		end else begin
			period_cnt = '0;
		end
		if (ph == PH_IDLE || ph == PH_DONE) begin
			go = start;
			if (regs.auto_mode && ph == PH_IDLE && period_cnt >= regs.sample_period_ticks) begin
				go = 1'b1;
				period_cnt = '0;
			end
			if (go) begin
				ph = PH_TRIG_LOW;
				ph_timer = '0;
			end
		end
		case (ph)
			PH_TRIG_LOW: begin
				r.busy_res = 1'b1;
				ph_timer++;
				if (ph_timer >= LOW_TICKS) begin
					ph = PH_TRIG_HIGH;
					ph_timer = '0;
				end
			end
			PH_TRIG_HIGH: begin
				r.busy_res = 1'b1;
				r.trigger_level = 1'b1;
				ph_timer++;
				if (ph_timer >= HIGH_TICKS) begin
					ph = PH_WAIT_RISE;
					ph_timer = '0;
					escape_cnt = '0;
				end
			end
			PH_WAIT_RISE: begin
				r.busy_res = 1'b1;
				if (echo) begin
					ph = PH_MEASURE;
					pulse_ticks = '0;
					escape_cnt = '0;
				end else if (escape_expired()) begin
					escape_cnt = '0;
					ph = PH_IDLE;
					r.timed_out = 1'b1;
				end
			end
			PH_MEASURE: begin
				r.busy_res = 1'b1;
				if (pulse_ticks != '1)
					pulse_ticks++;
				if (!echo) begin
					cm = ECHO_COUNT_BITS_DEF'(pulse_ticks / TICKS_PER_CM / ROUND_TRIP);
					last_cm = (cm > DIST_MAX) ? DIST_MAX : cm[DIST_BITS-1:0];
					r.distance_valid = 1'b1;
					escape_cnt = '0;
					ph = regs.auto_mode ? PH_IDLE : PH_DONE;
				end else if (escape_expired()) begin
					escape_cnt = '0;
					ph = PH_IDLE;
					r.timed_out = 1'b1;
				end
			end
			default: ;
		endcase
		r.range_cm = last_cm;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DIST_BITS-1:0] want,
			input logic [DIST_BITS-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs.auto_mode = AUTO_MODE_RST;
			regs.sample_period_ticks = SAMPLE_PERIOD_RST;
			regs.echo_timeout_ticks = ECHO_TIMEOUT_RST;
			ph = PH_IDLE;
			ph_timer = '0;
			escape_cnt = '0;
			pulse_ticks = '0;
			period_cnt = '0;
			last_cm = '0;
			expected_q.delete();
			mismatches = 0;
			distances_seen = 0;
			timeouts_seen = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_AUTO_MODE:     regs.auto_mode = cfg.data[0];
					CFG_SAMPLE_PERIOD: regs.sample_period_ticks = cfg.data[PERIOD_REG_BITS-1:0];
					CFG_ECHO_TIMEOUT:  regs.echo_timeout_ticks = cfg.data[TIMEOUT_REG_BITS-1:0];
					default: ;
				endcase
			end
			// pop before push: a result word can never belong to this edge's tick
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: result word expected none actual range %0d", $time,
						result.range_cm);
				end else begin
					want = expected_q.pop_front();
					check_field("trigger_level", DIST_BITS'(want.trigger_level),
						DIST_BITS'(result.trigger_level));
					check_field("range_cm", want.range_cm, result.range_cm);
					check_field("distance_valid", DIST_BITS'(want.distance_valid),
						DIST_BITS'(result.distance_valid));
					check_field("timed_out", DIST_BITS'(want.timed_out),
						DIST_BITS'(result.timed_out));
					check_field("busy_res", DIST_BITS'(want.busy_res),
						DIST_BITS'(result.busy_res));
					if (want.distance_valid)
						distances_seen++;
					if (want.timed_out)
						timeouts_seen++;
				end
			end
			if (tick.valid && tick.ready)
				expected_q.push_back(advance(tick.echo_level, tick.start_request));
			pending <= expected_q.size();
		end
	end

endmodule

// File: tb/sv/ultrasonic_range_sequencer_core_tb.sv
module ultrasonic_range_sequencer_core_tb;
	import urs_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	urs_in_if  tick_ch();
	urs_out_if result_ch();
	urs_cfg_if cfg_ch();

	int mismatches;
	int pending;
	int distances_seen;
	int timeouts_seen;

	int ticks_sent = 0;
	int cur_timeout = ECHO_TIMEOUT_RST;
	int hold_token = 0;
	bit calm = 1'b0;

	ultrasonic_range_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	range_sequencer_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick_ch),
		.result         (result_ch),
		.cfg            (cfg_ch),
		.mismatches     (mismatches),
		.pending        (pending),
		.distances_seen (distances_seen),
		.timeouts_seen  (timeouts_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// result receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
			end
		end
	end

	function automatic int cap_at(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	task automatic send_tick(input logic echo, input logic start);
		while (!calm && $urandom_range(0, 99) < 28) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.echo_level <= echo;
		tick_ch.start_request <= start;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		ticks_sent++;
	endtask

	// start word, trigger words with ignored noise, echo gap, pulse, falling edge
	task automatic ping(input int rise_delay, input int pulse_len);
		int k;
		send_tick(1'($urandom), 1'b1);
		for (k = 0; k < 6; k++)
			send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
		for (k = 0; k < rise_delay; k++)
			send_tick(1'b0, 1'b0);
		for (k = 0; k < pulse_len; k++)
			send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
	endtask

	task automatic settle();
		int n;
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		for (n = 0; pending != 0 && n < 100000; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_DATA_BITS'(value);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic set_regs(input int unsigned auto_on, input int unsigned period,
			input int unsigned timeout);
		write_reg(CFG_AUTO_MODE, auto_on);
		write_reg(CFG_SAMPLE_PERIOD, period);
		write_reg(CFG_ECHO_TIMEOUT, timeout);
		cfg_ch.valid <= 1'b0;
		cur_timeout = timeout;
	endtask

	task automatic run_pings(input int budget);
		int stop_at;
		int t;
		int kind;
		int n;
		int k;
		stop_at = ticks_sent + budget;
		t = (cur_timeout < 1) ? 1 : cur_timeout;
		while (ticks_sent < stop_at) begin
			kind = $urandom_range(0, 7);
			// missing or stuck echo would take too long with a large timeout
			if (t > 500 && (kind == 1 || kind == 2))
				kind = 0;
			case (kind)
				0: begin
					n = $urandom_range(4, 30);
					for (k = 0; k < n; k++)
						send_tick(1'($urandom), $urandom_range(0, 9) == 0);
				end
				1: ping($urandom_range(t, t + 4), 0);
				2: ping($urandom_range(0, cap_at(t - 1, 24)), $urandom_range(t + 1, t + 4));
				default: ping($urandom_range(0, cap_at(t - 1, 24)),
					$urandom_range(1, cap_at(t, ($urandom_range(0, 5) == 0) ? 700 : 120)));
			endcase
		end
	endtask

	initial begin
		tick_ch.valid <= 1'b0;
		tick_ch.echo_level <= 1'b0;
		tick_ch.start_request <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_AUTO_MODE;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle words, then a short echo straight after the trigger
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		ping(0, 2);
		settle();
		// zero timeout: first waiting word aborts
		set_regs(0, SAMPLE_PERIOD_RST, 0);
		ping(1, 0);
		settle();

		set_regs(0, SAMPLE_PERIOD_RST, 300);
		run_pings(180);
		settle();
		// period zero restarts right after each measurement
		set_regs(1, 0, 40);
		run_pings(160);
		settle();
		set_regs(1, 1, 1);
		run_pings(80);
		settle();
		set_regs(1, $urandom_range(30, 150), $urandom_range(100, 400));
		hold_token++;
		run_pings(180);
		settle();
		// long pulse under the widest timeout, no idling on either side
		calm = 1'b1;
		set_regs(0, 24'hFFFFFF, 65535);
		ping(0, 250);
		settle();
		calm = 1'b0;
		set_regs(1, 24'hFFFFFF, 65535);
		run_pings(40);
		settle();
		set_regs(0, 0, 0);
		run_pings(30);
		settle();

		$display("covered %0d tick words: %0d distances, %0d echo timeouts", ticks_sent,
			distances_seen, timeouts_seen);
		$display("manual and auto modes, period and timeout from zero to full scale");
		if (pending != 0)
			$display("%0t: %0d expected words never arrived", $time, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
